// ===== src/json_string_unescape_utf8_core_defines.svh =====
// Assertion macros for the JSON string unescape core.
// Used by the queue and output stage; expects clk and rst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape core.
// No dependencies.
package jsu_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [5:0] SURR_HI = 6'b110110;  // D800-DBFF
  localparam logic [5:0] SURR_LO = 6'b110111;  // DC00-DFFF

  typedef enum logic [3:0] {
    M_IDLE,
    M_STR,
    M_ESC,
    M_HEX0,
    M_HEX1,
    M_HEX2,
    M_HEX3,
    M_WBS,
    M_WU,
    M_LHEX0,
    M_LHEX1,
    M_LHEX2,
    M_LHEX3
  } mode_t;

  // Results of one input byte; b[0] goes out first, cnt is count minus one.
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      cnt;
    logic [3:0][7:0] b;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/json_string_unescape_utf8_core.sv =====
// Top level of the streaming JSON string unescape / UTF-8 encode core.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// Input channel (in_*): one text byte per word; in_tlast marks end of text
// (the byte is then ignored). A string starts with a double quote.
// Output channel (out_*): one result per word. out_tuser is the kind
// (0 decoded byte, 1 string ended, 2 invalid input), out_tdata the decoded
// byte (zero for kinds 1 and 2), out_tlast flags the final word caused by one
// input word. Escapes and hex digits give no output until the escape ends;
// a \u escape gives 1 to 4 UTF-8 bytes.
// With the output stage idle, the packet of an accepted input word is written
// into the queue and then loaded into the output register, where its first
// word is valid. The decoder takes one input word per cycle while the packet
// queue (QUEUE_DEPTH entries) has room; the output side sends one word per
// cycle while out_tready is high, one word per result byte or status.
// Reset (rst_n low, synchronous) empties the queue and returns the decoder to
// waiting for an opening quote. If out_tready is held low, the queue fills and
// in_tready drops; nothing is lost or reordered.
module json_string_unescape_utf8_core #(
  parameter int QUEUE_DEPTH = 4  // 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // last
);

  logic              accept;
  logic              push;
  logic              pop;
  jsu_pkg::pkt_t     wr_pkt;
  jsu_pkg::pkt_t     rd_pkt;
  jsu_pkg::q_stat_t  q_stat;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_eot  (in_tlast),
    .push    (push),
    .pkt     (wr_pkt)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_pkt),
    .pop     (pop),
    .rd_data (rd_pkt),
    .stat    (q_stat)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (rd_pkt),
    .q_empty   (q_stat.empty),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

// ===== src/jsu_front.sv =====
// Front decoder: per-byte escape / \u state machine, builds a result packet.
// Depends on jsu_pkg.
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_eot,
  output logic            push,
  output jsu_pkg::pkt_t   pkt
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [11:0]    acc_r, acc_nxt;
  logic [9:0]     hs_r, hs_nxt;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    // {valid, value}
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic jsu_pkg::pkt_t utf8_pkt(input logic [20:0] cp);
    jsu_pkg::pkt_t p;
    p      = '0;
    p.kind = jsu_pkg::KIND_DATA;
    if (cp <= 21'h7f) begin
      p.cnt  = 2'd0;
      p.b[0] = cp[7:0];
    end else if (cp <= 21'h7ff) begin
      p.cnt  = 2'd1;
      p.b[0] = {3'b110, cp[10:6]};
      p.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      p.cnt  = 2'd2;
      p.b[0] = {4'b1110, cp[15:12]};
      p.b[1] = {2'b10, cp[11:6]};
      p.b[2] = {2'b10, cp[5:0]};
    end else begin
      p.cnt  = 2'd3;
      p.b[0] = {5'b11110, cp[20:18]};
      p.b[1] = {2'b10, cp[17:12]};
      p.b[2] = {2'b10, cp[11:6]};
      p.b[3] = {2'b10, cp[5:0]};
    end
    return p;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::M_IDLE;
      acc_r  <= '0;
      hs_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
    end
  end

  always_comb begin
    logic [4:0]  hv;
    logic [15:0] v;
    logic [20:0] cp;
    logic        err;
    hv       = hex_val(in_byte);
    v        = {acc_r, hv[3:0]};
    cp       = 21'h10000 + {1'b0, hs_r, v[9:0]};
    err      = 1'b0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    hs_nxt   = hs_r;
    push     = 1'b0;
    pkt      = '0;
    if (accept) begin
      if (mode_r == jsu_pkg::M_IDLE) begin
        if (!in_eot) begin
          if (in_byte == jsu_pkg::CH_QUOTE) mode_nxt = jsu_pkg::M_STR;
          else                              err = 1'b1;
        end
      end else if (in_eot) begin
        err = 1'b1;
      end else begin
        unique case (mode_r)
          jsu_pkg::M_STR: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
              mode_nxt = jsu_pkg::M_IDLE;
              push     = 1'b1;
              pkt.kind = jsu_pkg::KIND_END;
            end else if (in_byte < jsu_pkg::CH_SPACE) begin
              err = 1'b1;
            end else if (in_byte == jsu_pkg::CH_BSL) begin
              mode_nxt = jsu_pkg::M_ESC;
            end else begin
              push     = 1'b1;
              pkt.kind = jsu_pkg::KIND_DATA;
              pkt.b[0] = in_byte;
            end
          end
          jsu_pkg::M_ESC: begin
            push     = 1'b1;
            pkt.kind = jsu_pkg::KIND_DATA;
            mode_nxt = jsu_pkg::M_STR;
            unique case (in_byte)
              jsu_pkg::CH_QUOTE: pkt.b[0] = jsu_pkg::CH_QUOTE;
              jsu_pkg::CH_BSL:   pkt.b[0] = jsu_pkg::CH_BSL;
              jsu_pkg::CH_SLASH: pkt.b[0] = jsu_pkg::CH_SLASH;
              jsu_pkg::CH_B:     pkt.b[0] = 8'h08;
              jsu_pkg::CH_F:     pkt.b[0] = 8'h0c;
              jsu_pkg::CH_N:     pkt.b[0] = 8'h0a;
              jsu_pkg::CH_R:     pkt.b[0] = 8'h0d;
              jsu_pkg::CH_T:     pkt.b[0] = 8'h09;
              jsu_pkg::CH_U: begin
                push     = 1'b0;
                acc_nxt  = '0;
                mode_nxt = jsu_pkg::M_HEX0;
              end
              default: err = 1'b1;
            endcase
          end
          jsu_pkg::M_WBS: begin
            if (in_byte == jsu_pkg::CH_BSL) mode_nxt = jsu_pkg::M_WU;
            else                            err = 1'b1;
          end
          jsu_pkg::M_WU: begin
            if (in_byte == jsu_pkg::CH_U) begin
              acc_nxt  = '0;
              mode_nxt = jsu_pkg::M_LHEX0;
            end else begin
              err = 1'b1;
            end
          end
          jsu_pkg::M_HEX0, jsu_pkg::M_HEX1, jsu_pkg::M_HEX2,
          jsu_pkg::M_LHEX0, jsu_pkg::M_LHEX1, jsu_pkg::M_LHEX2: begin
            if (!hv[4]) begin
              err = 1'b1;
            end else begin
              acc_nxt = v[11:0];
              unique case (mode_r)
                jsu_pkg::M_HEX0:  mode_nxt = jsu_pkg::M_HEX1;
                jsu_pkg::M_HEX1:  mode_nxt = jsu_pkg::M_HEX2;
                jsu_pkg::M_HEX2:  mode_nxt = jsu_pkg::M_HEX3;
                jsu_pkg::M_LHEX0: mode_nxt = jsu_pkg::M_LHEX1;
                jsu_pkg::M_LHEX1: mode_nxt = jsu_pkg::M_LHEX2;
                default:          mode_nxt = jsu_pkg::M_LHEX3;
              endcase
            end
          end
          jsu_pkg::M_HEX3: begin
            if (!hv[4] || v[15:10] == jsu_pkg::SURR_LO) begin
              err = 1'b1;
            end else if (v[15:10] == jsu_pkg::SURR_HI) begin
              hs_nxt   = v[9:0];
              mode_nxt = jsu_pkg::M_WBS;
            end else begin
              push     = 1'b1;
              pkt      = utf8_pkt({5'd0, v});
              mode_nxt = jsu_pkg::M_STR;
            end
          end
          jsu_pkg::M_LHEX3: begin
            if (!hv[4] || v[15:10] != jsu_pkg::SURR_LO) begin
              err = 1'b1;
            end else begin
              push     = 1'b1;
              pkt      = utf8_pkt(cp);
              mode_nxt = jsu_pkg::M_STR;
            end
          end
          default: err = 1'b1;
        endcase
      end
      if (err) begin
        mode_nxt = jsu_pkg::M_IDLE;
        acc_nxt  = '0;
        hs_nxt   = '0;
        push     = 1'b1;
        pkt      = '0;
        pkt.kind = jsu_pkg::KIND_ERR;
      end
    end
  end

endmodule

// ===== src/jsu_fifo.sv =====
// Packet queue between the decoder and the output stage.
// Depends on jsu_pkg and the core defines header.
`include "json_string_unescape_utf8_core_defines.svh"
module jsu_fifo #(
  parameter int DEPTH = 4  // 2 or more
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::pkt_t     wr_data,
  input  logic              pop,
  output jsu_pkg::pkt_t     rd_data,
  output jsu_pkg::q_stat_t  stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::pkt_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `JSU_ASSERT_IMP(a_no_overflow, push, !stat.full, "packet pushed into full queue")
  `JSU_ASSERT_IMP(a_no_underflow, pop, !stat.empty, "packet popped from empty queue")

endmodule

// ===== src/jsu_back.sv =====
// Output stage: holds a packet, sends one word per cycle while out_ready is high.
// Depends on jsu_pkg and the core defines header.
`include "json_string_unescape_utf8_core_defines.svh"
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsu_pkg::pkt_t     q_data,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_last
);

  jsu_pkg::pkt_t cur_r;
  logic [1:0]    idx_r;
  logic          vld_r;
  logic          xfer;
  logic          done;

  assign xfer      = vld_r && out_ready;
  assign out_last  = (idx_r == cur_r.cnt);
  assign done      = xfer && out_last;
  assign q_pop     = (!vld_r || done) && !q_empty;
  assign out_valid = vld_r;
  assign out_byte  = cur_r.b[idx_r];
  assign out_kind  = cur_r.kind;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (done) begin
      vld_r <= 1'b0;
    end else if (xfer) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  `JSU_ASSERT_IMP(a_single_status, vld_r && cur_r.kind != jsu_pkg::KIND_DATA,
                  cur_r.cnt == 2'd0 && cur_r.b == '0, "end or error packet not a lone zero word")
  `JSU_ASSERT_NXT(a_drain_idle, done && q_empty, !vld_r,
                  "output stage still valid after last word with empty queue")

endmodule
